/* rtl/core/lbau_pkg.sv */
// Shared types, operation codes and saturating arithmetic for the linear bound unit.
`timescale 1ns / 1ps

package lbau_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_CONCRETIZE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEGATE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD        = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MULTIPLY   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD_SCALAR = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SUB_SCALAR = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SCALE      = 3'd6;

  localparam int unsigned IN_DATA_W  = 360;
  localparam int unsigned OUT_DATA_W = 192;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t ls;
    word_t lo;
    word_t us;
    word_t uo;
  } bound_t;

  function automatic word_t sat_wide(input logic signed [WORD_W:0] v);
    word_t res;
    if (v[WORD_W] != v[WORD_W-1]) begin
      res = v[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      res = v[WORD_W-1:0];
    end
    return res;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_W:0] sum;
    sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    return sat_wide(sum);
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [WORD_W:0] dif;
    dif = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    return sat_wide(dif);
  endfunction

  function automatic word_t sat_neg(input word_t a);
    logic signed [WORD_W:0] neg;
    neg = -{a[WORD_W-1], a};
    return sat_wide(neg);
  endfunction

  function automatic word_t min_w(input word_t a, input word_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic word_t max_w(input word_t a, input word_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* rtl/core/linear_bound_arithmetic_unit.sv */
// Top level of the linear bound arithmetic unit: an eight-stage pipeline.
`timescale 1ns / 1ps

// The unit takes one transfer per clock while the pipeline is not stalled and returns one
// result transfer for each, in order, once the output side is ready. Operands pass two ranks of
// concretizing multipliers (one for the operands, one for the result) with the multiply rank
// between them; every rank is followed by a register. Each stage holds its item while the
// stage behind it is full and stalled, so bubbles close up and the input stays ready until
// the pipeline is completely full and stalled.

module linear_bound_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: cmd, delta_low, delta_high, a_lower_slope, a_lower_offset,
  // a_upper_slope, a_upper_offset, b_lower_slope, b_lower_offset, b_upper_slope,
  // b_upper_offset, scalar_value, zero padding.
  input  logic [lbau_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: out_lower_slope, out_lower_offset, out_upper_slope,
  // out_upper_offset, interval_low, interval_high.
  output logic [lbau_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Fields from bit 0: domain_error.
  output logic                                out_tuser
);

  localparam int unsigned NSTG = 8;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = NSTG - 1; k >= 1; k--) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
    end
  end

  // Input unpacking.
  logic [lbau_pkg::CMD_W-1:0] in_cmd;
  lbau_pkg::word_t            in_dlo, in_dhi, in_s;
  lbau_pkg::bound_t           in_a, in_b;

  assign in_cmd  = in_tdata[2:0];
  assign in_dlo  = in_tdata[34:3];
  assign in_dhi  = in_tdata[66:35];
  assign in_a.ls = in_tdata[98:67];
  assign in_a.lo = in_tdata[130:99];
  assign in_a.us = in_tdata[162:131];
  assign in_a.uo = in_tdata[194:163];
  assign in_b.ls = in_tdata[226:195];
  assign in_b.lo = in_tdata[258:227];
  assign in_b.us = in_tdata[290:259];
  assign in_b.uo = in_tdata[322:291];
  assign in_s    = in_tdata[354:323];

  // Stage 1: concretizing products of both operands and scaling products.
  lbau_pkg::word_t m1_x [12];
  lbau_pkg::word_t m1_y [12];
  lbau_pkg::word_t m1_p [12];

  always_comb begin
    m1_x[0]  = in_dlo;  m1_y[0]  = in_a.ls;
    m1_x[1]  = in_dhi;  m1_y[1]  = in_a.ls;
    m1_x[2]  = in_dlo;  m1_y[2]  = in_a.us;
    m1_x[3]  = in_dhi;  m1_y[3]  = in_a.us;
    m1_x[4]  = in_dlo;  m1_y[4]  = in_b.ls;
    m1_x[5]  = in_dhi;  m1_y[5]  = in_b.ls;
    m1_x[6]  = in_dlo;  m1_y[6]  = in_b.us;
    m1_x[7]  = in_dhi;  m1_y[7]  = in_b.us;
    m1_x[8]  = in_a.ls; m1_y[8]  = in_s;
    m1_x[9]  = in_a.lo; m1_y[9]  = in_s;
    m1_x[10] = in_a.us; m1_y[10] = in_s;
    m1_x[11] = in_a.uo; m1_y[11] = in_s;
  end

  for (genvar g = 0; g < 12; g++) begin : g_mul1
    lbau_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .a(m1_x[g]),
      .b(m1_y[g]),
      .y(m1_p[g])
    );
  end

  logic [lbau_pkg::CMD_W-1:0] s1_cmd_r;
  lbau_pkg::word_t            s1_dlo_r, s1_dhi_r, s1_s_r;
  lbau_pkg::bound_t           s1_a_r, s1_b_r;
  lbau_pkg::word_t            s1_p_r [12];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_cmd_r <= in_cmd;
      s1_dlo_r <= in_dlo;
      s1_dhi_r <= in_dhi;
      s1_s_r   <= in_s;
      s1_a_r   <= in_a;
      s1_b_r   <= in_b;
      for (int i = 0; i < 12; i++) begin
        s1_p_r[i] <= m1_p[i];
      end
    end
  end

  // Stage 2: offset sums for both operands and the result of the simple operations.
  lbau_pkg::bound_t s2_ra_nxt;
  lbau_pkg::word_t  s2_ca_nxt [4];
  lbau_pkg::word_t  s2_cb_nxt [4];

  always_comb begin
    s2_ca_nxt[0] = lbau_pkg::sat_add(s1_p_r[0], s1_a_r.lo);
    s2_ca_nxt[1] = lbau_pkg::sat_add(s1_p_r[1], s1_a_r.lo);
    s2_ca_nxt[2] = lbau_pkg::sat_add(s1_p_r[2], s1_a_r.uo);
    s2_ca_nxt[3] = lbau_pkg::sat_add(s1_p_r[3], s1_a_r.uo);
    s2_cb_nxt[0] = lbau_pkg::sat_add(s1_p_r[4], s1_b_r.lo);
    s2_cb_nxt[1] = lbau_pkg::sat_add(s1_p_r[5], s1_b_r.lo);
    s2_cb_nxt[2] = lbau_pkg::sat_add(s1_p_r[6], s1_b_r.uo);
    s2_cb_nxt[3] = lbau_pkg::sat_add(s1_p_r[7], s1_b_r.uo);
    s2_ra_nxt = s1_a_r;
    case (s1_cmd_r)
      lbau_pkg::CMD_NEGATE: begin
        s2_ra_nxt.ls = lbau_pkg::sat_neg(s1_a_r.us);
        s2_ra_nxt.lo = lbau_pkg::sat_neg(s1_a_r.uo);
        s2_ra_nxt.us = lbau_pkg::sat_neg(s1_a_r.ls);
        s2_ra_nxt.uo = lbau_pkg::sat_neg(s1_a_r.lo);
      end
      lbau_pkg::CMD_ADD: begin
        s2_ra_nxt.ls = lbau_pkg::sat_add(s1_a_r.ls, s1_b_r.ls);
        s2_ra_nxt.lo = lbau_pkg::sat_add(s1_a_r.lo, s1_b_r.lo);
        s2_ra_nxt.us = lbau_pkg::sat_add(s1_a_r.us, s1_b_r.us);
        s2_ra_nxt.uo = lbau_pkg::sat_add(s1_a_r.uo, s1_b_r.uo);
      end
      lbau_pkg::CMD_ADD_SCALAR: begin
        s2_ra_nxt.lo = lbau_pkg::sat_add(s1_a_r.lo, s1_s_r);
        s2_ra_nxt.uo = lbau_pkg::sat_add(s1_a_r.uo, s1_s_r);
      end
      lbau_pkg::CMD_SUB_SCALAR: begin
        s2_ra_nxt.lo = lbau_pkg::sat_sub(s1_a_r.lo, s1_s_r);
        s2_ra_nxt.uo = lbau_pkg::sat_sub(s1_a_r.uo, s1_s_r);
      end
      lbau_pkg::CMD_SCALE: begin
        if (s1_s_r > 0) begin
          s2_ra_nxt.ls = s1_p_r[8];
          s2_ra_nxt.lo = s1_p_r[9];
          s2_ra_nxt.us = s1_p_r[10];
          s2_ra_nxt.uo = s1_p_r[11];
        end else begin
          s2_ra_nxt.ls = s1_p_r[10];
          s2_ra_nxt.lo = s1_p_r[11];
          s2_ra_nxt.us = s1_p_r[8];
          s2_ra_nxt.uo = s1_p_r[9];
        end
      end
      default: begin
        s2_ra_nxt = s1_a_r;
      end
    endcase
  end

  logic             s2_mul_r;
  lbau_pkg::word_t  s2_dlo_r, s2_dhi_r;
  lbau_pkg::bound_t s2_a_r, s2_b_r, s2_ra_r;
  lbau_pkg::word_t  s2_ca_r [4];
  lbau_pkg::word_t  s2_cb_r [4];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_mul_r <= (s1_cmd_r == lbau_pkg::CMD_MULTIPLY);
      s2_dlo_r <= s1_dlo_r;
      s2_dhi_r <= s1_dhi_r;
      s2_a_r   <= s1_a_r;
      s2_b_r   <= s1_b_r;
      s2_ra_r  <= s2_ra_nxt;
      for (int i = 0; i < 4; i++) begin
        s2_ca_r[i] <= s2_ca_nxt[i];
        s2_cb_r[i] <= s2_cb_nxt[i];
      end
    end
  end

  // Stage 3: operand intervals.
  logic             s3_mul_r;
  lbau_pkg::word_t  s3_dlo_r, s3_dhi_r;
  lbau_pkg::bound_t s3_a_r, s3_b_r, s3_ra_r;
  lbau_pkg::word_t  s3_ai_r, s3_as_r, s3_bi_r, s3_bs_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_mul_r <= s2_mul_r;
      s3_dlo_r <= s2_dlo_r;
      s3_dhi_r <= s2_dhi_r;
      s3_a_r   <= s2_a_r;
      s3_b_r   <= s2_b_r;
      s3_ra_r  <= s2_ra_r;
      s3_ai_r  <= lbau_pkg::min_w(s2_ca_r[0], s2_ca_r[1]);
      s3_as_r  <= lbau_pkg::max_w(s2_ca_r[2], s2_ca_r[3]);
      s3_bi_r  <= lbau_pkg::min_w(s2_cb_r[0], s2_cb_r[1]);
      s3_bs_r  <= lbau_pkg::max_w(s2_cb_r[2], s2_cb_r[3]);
    end
  end

  // Stage 4: width comparison, choice of multiplier operands and the domain error check.
  logic signed [lbau_pkg::WORD_W:0] s4_wa, s4_wb;
  logic                             s4_use_a;
  lbau_pkg::word_t                  s4_x_nxt [4];
  lbau_pkg::word_t                  s4_y_nxt [4];

  assign s4_wa    = {s3_as_r[lbau_pkg::WORD_W-1], s3_as_r} - {s3_ai_r[lbau_pkg::WORD_W-1], s3_ai_r};
  assign s4_wb    = {s3_bs_r[lbau_pkg::WORD_W-1], s3_bs_r} - {s3_bi_r[lbau_pkg::WORD_W-1], s3_bi_r};
  assign s4_use_a = (s4_wa < s4_wb);

  always_comb begin
    if (s4_use_a) begin
      s4_x_nxt[0] = s3_ai_r; s4_y_nxt[0] = s3_b_r.ls;
      s4_x_nxt[1] = s3_ai_r; s4_y_nxt[1] = s3_b_r.lo;
      s4_x_nxt[2] = s3_as_r; s4_y_nxt[2] = s3_b_r.us;
      s4_x_nxt[3] = s3_as_r; s4_y_nxt[3] = s3_b_r.uo;
    end else begin
      s4_x_nxt[0] = s3_bi_r; s4_y_nxt[0] = s3_a_r.ls;
      s4_x_nxt[1] = s3_bi_r; s4_y_nxt[1] = s3_a_r.lo;
      s4_x_nxt[2] = s3_bs_r; s4_y_nxt[2] = s3_a_r.us;
      s4_x_nxt[3] = s3_bs_r; s4_y_nxt[3] = s3_a_r.uo;
    end
  end

  logic             s4_mul_r, s4_err_r;
  lbau_pkg::word_t  s4_dlo_r, s4_dhi_r;
  lbau_pkg::bound_t s4_ra_r;
  lbau_pkg::word_t  s4_x_r [4];
  lbau_pkg::word_t  s4_y_r [4];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_mul_r <= s3_mul_r;
      s4_err_r <= s3_mul_r && (s3_ai_r[lbau_pkg::WORD_W-1] || s3_bi_r[lbau_pkg::WORD_W-1]);
      s4_dlo_r <= s3_dlo_r;
      s4_dhi_r <= s3_dhi_r;
      s4_ra_r  <= s3_ra_r;
      for (int i = 0; i < 4; i++) begin
        s4_x_r[i] <= s4_x_nxt[i];
        s4_y_r[i] <= s4_y_nxt[i];
      end
    end
  end

  // Stage 5: bound multiplication and choice between its product and the simple result.
  lbau_pkg::word_t m5_p [4];

  for (genvar g = 0; g < 4; g++) begin : g_mul5
    lbau_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .a(s4_x_r[g]),
      .b(s4_y_r[g]),
      .y(m5_p[g])
    );
  end

  logic             s5_err_r;
  lbau_pkg::word_t  s5_dlo_r, s5_dhi_r;
  lbau_pkg::bound_t s5_r_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_err_r <= s4_err_r;
      s5_dlo_r <= s4_dlo_r;
      s5_dhi_r <= s4_dhi_r;
      if (s4_mul_r) begin
        s5_r_r <= '{ls: m5_p[0], lo: m5_p[1], us: m5_p[2], uo: m5_p[3]};
      end else begin
        s5_r_r <= s4_ra_r;
      end
    end
  end

  // Stage 6: concretizing products of the result.
  lbau_pkg::word_t m6_x [4];
  lbau_pkg::word_t m6_y [4];
  lbau_pkg::word_t m6_p [4];

  always_comb begin
    m6_x[0] = s5_dlo_r; m6_y[0] = s5_r_r.ls;
    m6_x[1] = s5_dhi_r; m6_y[1] = s5_r_r.ls;
    m6_x[2] = s5_dlo_r; m6_y[2] = s5_r_r.us;
    m6_x[3] = s5_dhi_r; m6_y[3] = s5_r_r.us;
  end

  for (genvar g = 0; g < 4; g++) begin : g_mul6
    lbau_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .a(m6_x[g]),
      .b(m6_y[g]),
      .y(m6_p[g])
    );
  end

  logic             s6_err_r;
  lbau_pkg::bound_t s6_r_r;
  lbau_pkg::word_t  s6_p_r [4];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_err_r <= s5_err_r;
      s6_r_r   <= s5_r_r;
      for (int i = 0; i < 4; i++) begin
        s6_p_r[i] <= m6_p[i];
      end
    end
  end

  // Stage 7: result offset sums.
  logic             s7_err_r;
  lbau_pkg::bound_t s7_r_r;
  lbau_pkg::word_t  s7_c_r [4];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_err_r  <= s6_err_r;
      s7_r_r    <= s6_r_r;
      s7_c_r[0] <= lbau_pkg::sat_add(s6_p_r[0], s6_r_r.lo);
      s7_c_r[1] <= lbau_pkg::sat_add(s6_p_r[1], s6_r_r.lo);
      s7_c_r[2] <= lbau_pkg::sat_add(s6_p_r[2], s6_r_r.uo);
      s7_c_r[3] <= lbau_pkg::sat_add(s6_p_r[3], s6_r_r.uo);
    end
  end

  // Stage 8: result interval, which is also the output register.
  logic             s8_err_r;
  lbau_pkg::bound_t s8_r_r;
  lbau_pkg::word_t  s8_ilo_r, s8_ihi_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s8_err_r <= s7_err_r;
      s8_r_r   <= s7_r_r;
      s8_ilo_r <= lbau_pkg::min_w(s7_c_r[0], s7_c_r[1]);
      s8_ihi_r <= lbau_pkg::max_w(s7_c_r[2], s7_c_r[3]);
    end
  end

  assign out_tdata = {s8_ihi_r, s8_ilo_r, s8_r_r.uo, s8_r_r.us, s8_r_r.lo, s8_r_r.ls};
  assign out_tuser = s8_err_r;

endmodule

/* rtl/core/lbau_fx_mul.sv */
// Fixed-point multiplier: exact product, floor shift by the fraction width, saturation.
`timescale 1ns / 1ps

module lbau_fx_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  lbau_pkg::word_t a,
  input  lbau_pkg::word_t b,
  output lbau_pkg::word_t y
);

  localparam int unsigned PROD_W = 2 * lbau_pkg::WORD_W;
  localparam int unsigned SHR_W  = PROD_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod;
  logic signed [SHR_W-1:0]  shr;
  logic                     ovf;

  assign prod = a * b;
  assign shr  = prod[PROD_W-1:FRAC_BITS];
  assign ovf  = (shr[SHR_W-1:lbau_pkg::WORD_W-1] != {(SHR_W-lbau_pkg::WORD_W+1){1'b0}})
             && (shr[SHR_W-1:lbau_pkg::WORD_W-1] != {(SHR_W-lbau_pkg::WORD_W+1){1'b1}});

  always_comb begin
    if (ovf) begin
      y = shr[SHR_W-1] ? lbau_pkg::WORD_MIN : lbau_pkg::WORD_MAX;
    end else begin
      y = shr[lbau_pkg::WORD_W-1:0];
    end
  end

endmodule

/* bench/linear_bound_arithmetic_unit_tb.sv */
// Self-checking testbench for the linear bound arithmetic unit under random stream handshakes.
`timescale 1ns / 1ps

module linear_bound_arithmetic_unit_tb;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned RANDOM_OPS   = 1450;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef lbau_pkg::word_t word_t;

  localparam word_t ONE  = 32'sh0001_0000;
  localparam word_t MAXW = lbau_pkg::WORD_MAX;
  localparam word_t MINW = lbau_pkg::WORD_MIN;
  localparam logic [lbau_pkg::CMD_W-1:0] CMD_SPARE = 3'd7;

  // Laid out so that the struct is the input transfer word itself.
  typedef struct packed {
    logic [4:0] pad;
    word_t scalar;
    word_t b_uo, b_us, b_lo, b_ls;
    word_t a_uo, a_us, a_lo, a_ls;
    word_t d_hi, d_lo;
    logic [lbau_pkg::CMD_W-1:0] cmd;
  } bound_op_t;

  // Laid out as {out_tuser, out_tdata}.
  typedef struct packed {
    logic err;
    word_t ihi, ilo, uo, us, lo, ls;
  } bound_result_t;

  typedef struct packed {
    word_t ls, lo, us, uo;
  } lin_bound_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lbau_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lbau_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  bound_op_t     pending_ops[$];
  bound_result_t bound_expect[$];
  bound_op_t     op_on_bus;
  int unsigned   send_wait, send_calm, recv_wait, recv_calm;
  int            results_seen = 0;
  int            cycle_count = 0;
  int            mismatches = 0;
  logic          hold_off = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   holds_done = 0;

  linear_bound_arithmetic_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial forever #10 clk = ~clk;

  function automatic word_t clamp_word(longint v);
    longint c;
    c = v;
    if (v > 64'sd2147483647) c = 64'sd2147483647;
    if (v < -64'sd2147483648) c = -64'sd2147483648;
    return c[31:0];
  endfunction

  // Full product, then an arithmetic shift, which floors toward minus infinity.
  function automatic word_t q_mul(word_t a, word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_word(p >>> FRAC_BITS);
  endfunction

  function automatic word_t q_add(word_t a, word_t b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  function automatic void span_of(lin_bound_t x, word_t dl, word_t dh,
                                  output word_t lo, output word_t hi);
    word_t l1, l2, h1, h2;
    l1 = q_add(q_mul(dl, x.ls), x.lo);
    l2 = q_add(q_mul(dh, x.ls), x.lo);
    h1 = q_add(q_mul(dl, x.us), x.uo);
    h2 = q_add(q_mul(dh, x.us), x.uo);
    lo = (l1 < l2) ? l1 : l2;
    hi = (h1 > h2) ? h1 : h2;
  endfunction

  function automatic bound_result_t predict_bound_op(bound_op_t op);
    lin_bound_t a, b, r;
    word_t a_inf, a_sup, b_inf, b_sup, s;
    bound_result_t res;
    a = '{op.a_ls, op.a_lo, op.a_us, op.a_uo};
    b = '{op.b_ls, op.b_lo, op.b_us, op.b_uo};
    s = op.scalar;
    r = a;
    res = '0;
    case (op.cmd)
      lbau_pkg::CMD_NEGATE: begin
        r.ls = clamp_word(-longint'(a.us));
        r.lo = clamp_word(-longint'(a.uo));
        r.us = clamp_word(-longint'(a.ls));
        r.uo = clamp_word(-longint'(a.lo));
      end
      lbau_pkg::CMD_ADD: begin
        r.ls = q_add(a.ls, b.ls);
        r.lo = q_add(a.lo, b.lo);
        r.us = q_add(a.us, b.us);
        r.uo = q_add(a.uo, b.uo);
      end
      lbau_pkg::CMD_MULTIPLY: begin
        span_of(a, op.d_lo, op.d_hi, a_inf, a_sup);
        span_of(b, op.d_lo, op.d_hi, b_inf, b_sup);
        res.err = (a_inf < 0) || (b_inf < 0);
        if (longint'(a_sup) - longint'(a_inf) < longint'(b_sup) - longint'(b_inf)) begin
          r = '{q_mul(a_inf, b.ls), q_mul(a_inf, b.lo), q_mul(a_sup, b.us), q_mul(a_sup, b.uo)};
        end else begin
          r = '{q_mul(b_inf, a.ls), q_mul(b_inf, a.lo), q_mul(b_sup, a.us), q_mul(b_sup, a.uo)};
        end
      end
      lbau_pkg::CMD_ADD_SCALAR: begin
        r.lo = q_add(a.lo, s);
        r.uo = q_add(a.uo, s);
      end
      lbau_pkg::CMD_SUB_SCALAR: begin
        r.lo = clamp_word(longint'(a.lo) - longint'(s));
        r.uo = clamp_word(longint'(a.uo) - longint'(s));
      end
      lbau_pkg::CMD_SCALE: begin
        if (s > 0) begin
          r = '{q_mul(a.ls, s), q_mul(a.lo, s), q_mul(a.us, s), q_mul(a.uo, s)};
        end else begin
          r = '{q_mul(a.us, s), q_mul(a.uo, s), q_mul(a.ls, s), q_mul(a.lo, s)};
        end
      end
      default: begin
      end
    endcase
    span_of(r, op.d_lo, op.d_hi, res.ilo, res.ihi);
    res.ls = r.ls;
    res.lo = r.lo;
    res.us = r.us;
    res.uo = r.uo;
    return res;
  endfunction

  function automatic bound_op_t make_op(logic [lbau_pkg::CMD_W-1:0] cmd, word_t dl, word_t dh,
                                        word_t als, word_t alo, word_t aus, word_t auo,
                                        word_t bls, word_t blo, word_t bus, word_t buo,
                                        word_t s);
    bound_op_t op;
    op = '{5'd0, s, buo, bus, blo, bls, auo, aus, alo, als, dh, dl, cmd};
    return op;
  endfunction

  function automatic word_t rand_word(int unsigned kind);
    word_t w;
    case (kind)
      0: w = $urandom;
      1: w = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: begin
        case ($urandom_range(0, 6))
          0: w = MAXW;
          1: w = MINW;
          2: w = 0;
          3: w = 1;
          4: w = -1;
          5: w = ONE;
          default: w = -ONE;
        endcase
      end
    endcase
    return w;
  endfunction

  // Well-formed multiplies have non-negative operand intervals; the rest is free-form.
  function automatic bound_op_t random_op();
    bound_op_t op;
    int unsigned style;
    op = '0;
    style = $urandom_range(0, 9);
    op.cmd = lbau_pkg::CMD_W'($urandom_range(0, 7));
    if (style == 4 || style == 5) begin
      op.cmd = lbau_pkg::CMD_MULTIPLY;
      op.d_lo = $urandom_range(0, 2 * ONE);
      op.d_hi = op.d_lo + $urandom_range(0, ONE);
      op.a_ls = $signed($urandom_range(0, 2 * ONE)) - ONE;
      op.a_us = $signed($urandom_range(0, 2 * ONE)) - ONE;
      op.b_ls = $signed($urandom_range(0, 2 * ONE)) - ONE;
      op.b_us = $signed($urandom_range(0, 2 * ONE)) - ONE;
      op.a_lo = $urandom_range(3 * ONE, 8 * ONE);
      op.b_lo = $urandom_range(3 * ONE, 8 * ONE);
      op.a_uo = op.a_lo + $urandom_range(0, 6 * ONE);
      op.b_uo = op.b_lo + $urandom_range(0, 6 * ONE);
      op.scalar = $urandom;
    end else begin
      for (int f = 0; f < 11; f++) begin
        if (style <= 3) op[3 + 32 * f +: 32] = rand_word(1);
        else if (style <= 7) op[3 + 32 * f +: 32] = rand_word(0);
        else op[3 + 32 * f +: 32] = rand_word($urandom_range(0, 2));
      end
    end
    return op;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    int unsigned w;
    if (calm != 0) begin
      calm--;
      w = 0;
    end else begin
      w = $urandom_range(0, 13);
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 60);
    end
    return w;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("cycle %0d: %s", cycle_count, msg);
  endtask

  initial begin
    pending_ops.push_back(make_op(lbau_pkg::CMD_CONCRETIZE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_CONCRETIZE, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
                                  MAXW, MAXW, MAXW, MAXW, MAXW));
    pending_ops.push_back(make_op(lbau_pkg::CMD_CONCRETIZE, MINW, MINW, MINW, MINW, MINW, MINW,
                                  MINW, MINW, MINW, MINW, MINW));
    pending_ops.push_back(make_op(lbau_pkg::CMD_NEGATE, ONE, 2 * ONE, MINW, MINW, MINW, MINW,
                                  0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_NEGATE, -ONE, ONE, ONE, -2 * ONE, 3 * ONE, 5 * ONE,
                                  0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_ADD, 0, ONE, MAXW, MAXW, MAXW, MAXW,
                                  MAXW, MAXW, MAXW, MAXW, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_ADD, 0, ONE, MINW, MINW, MINW, MINW,
                                  MINW, MINW, MINW, MINW, 0));
    // Operand A reaches below zero, so the multiply raises the domain error.
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, 0, ONE, 0, -ONE, 0, ONE,
                                  0, ONE, 0, 2 * ONE, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, 0, ONE, 0, ONE, 0, 2 * ONE,
                                  0, 2 * ONE, 0, 5 * ONE, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, 0, ONE, 0, 2 * ONE, 0, 5 * ONE,
                                  0, ONE, 0, 2 * ONE, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, 0, ONE, ONE, ONE, ONE, 2 * ONE,
                                  0, 3 * ONE, 0, 5 * ONE, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
                                  MAXW, MAXW, MAXW, MAXW, MAXW));
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, MINW, MAXW, ONE, MINW, -ONE, MAXW,
                                  MAXW, 0, MINW, ONE, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_ADD_SCALAR, 0, ONE, 0, MAXW, 0, ONE,
                                  0, 0, 0, 0, MAXW));
    pending_ops.push_back(make_op(lbau_pkg::CMD_SUB_SCALAR, 0, ONE, 0, 0, 0, MAXW,
                                  0, 0, 0, 0, MINW));
    pending_ops.push_back(make_op(lbau_pkg::CMD_SUB_SCALAR, -ONE, ONE, ONE, ONE, ONE, 2 * ONE,
                                  0, 0, 0, 0, 3 * ONE / 2));
    pending_ops.push_back(make_op(lbau_pkg::CMD_SCALE, -ONE, ONE, ONE, -2 * ONE, 3 * ONE, 4 * ONE,
                                  0, 0, 0, 0, ONE / 2));
    pending_ops.push_back(make_op(lbau_pkg::CMD_SCALE, -ONE, ONE, ONE, -2 * ONE, 3 * ONE, 4 * ONE,
                                  0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_SCALE, -ONE, ONE, ONE, -2 * ONE, 3 * ONE, 4 * ONE,
                                  0, 0, 0, 0, -3 * ONE));
    pending_ops.push_back(make_op(lbau_pkg::CMD_SCALE, MINW, MINW, MINW, MINW, MINW, MINW,
                                  0, 0, 0, 0, MINW));
    // A tiny negative product must floor rather than round toward zero.
    pending_ops.push_back(make_op(lbau_pkg::CMD_SCALE, 0, ONE, -1, -1, 1, 1,
                                  0, 0, 0, 0, ONE + 1));
    pending_ops.push_back(make_op(CMD_SPARE, 0, ONE, ONE, 2 * ONE, 3 * ONE, 4 * ONE,
                                  5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE));
    pending_ops.push_back(make_op(lbau_pkg::CMD_CONCRETIZE, 2 * ONE, -ONE, ONE, 0, -ONE, ONE,
                                  0, 0, 0, 0, 0));
    pending_ops.push_back(make_op(lbau_pkg::CMD_MULTIPLY, ONE, 0, 0, ONE, ONE, 2 * ONE,
                                  0, ONE, 0, 4 * ONE, 0));
    repeat (RANDOM_OPS) pending_ops.push_back(random_op());

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_ops.size() != 0 || in_tvalid || bound_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && bound_expect.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait = 0;
      send_calm = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        bound_expect.push_back(predict_bound_op(op_on_bus));
        offer = 1'b0;
        send_wait = draw_wait(send_calm);
        if (hold_off) send_wait = 0;
      end
      if (!offer) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (pending_ops.size() != 0) begin
          op_on_bus = pending_ops.pop_front();
          in_tdata <= op_on_bus;
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // The receiver stops twice for a long stretch so that the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold_off <= (hold_left != 1);
    end else if (holds_done < 2 && results_seen >= 300 + 700 * holds_done) begin
      hold_off <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    bound_result_t seen, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
      recv_calm = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = {out_tuser, out_tdata};
        results_seen <= results_seen + 1;
        if (bound_expect.size() == 0) begin
          note_mismatch($sformatf("result transfer with none expected: %h", seen));
        end else begin
          want = bound_expect.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (seen[32 * f +: 32] !== want[32 * f +: 32]) begin
              note_mismatch($sformatf("result %0d word %0d: expected %h, got %h",
                                      results_seen, f, want[32 * f +: 32], seen[32 * f +: 32]));
            end
          end
          if (seen.err !== want.err) begin
            note_mismatch($sformatf("result %0d domain error: expected %b, got %b",
                                    results_seen, want.err, seen.err));
          end
        end
        recv_wait = draw_wait(recv_calm);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_tready <= (recv_wait == 0) && !hold_off;
    end
  end

endmodule

/* sim.f */
rtl/core/lbau_pkg.sv
rtl/core/lbau_fx_mul.sv
rtl/core/linear_bound_arithmetic_unit.sv
bench/linear_bound_arithmetic_unit_tb.sv
